[rtl/hsde_pkg.sv]
// ----------------------------------------------------------------------------
// hsde_pkg
// Shared widths, codes and control types of the heightmap erosion block.
// ----------------------------------------------------------------------------
package hsde_pkg;

  localparam int MAX_MAP_SIZE = 1024;
  localparam int MIN_MAP_SIZE = 3;
  localparam int ADDR_W       = $clog2(MAX_MAP_SIZE);
  localparam int SIZE_W       = 11;
  localparam int FILL_W       = $clog2(MAX_MAP_SIZE + 2);
  localparam int HEIGHT_W     = 16;
  localparam int GAIN_W       = 16;
  localparam int PROD_W       = HEIGHT_W + GAIN_W;
  localparam int CFG_INDEX_W  = 1;
  localparam int CFG_DATA_W   = 16;
  localparam int SIZE_RESET   = (1024 > MAX_MAP_SIZE) ? MAX_MAP_SIZE : 1024;
  localparam int GAIN_RESET   = 6554;

  typedef logic [HEIGHT_W-1:0] height_t;
  typedef logic [ADDR_W-1:0]   addr_t;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] REG_MAP_SIZE     = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_EROSION_GAIN = 1'b1;

  typedef struct packed {
    logic  pix;      // pixel written to the raw line
    logic  adv;      // raw line position steps
    logic  produce;  // a result leaves with this request
    logic  last;     // final pixel of the frame
    logic  border;   // result pixel sits on the frame border
    addr_t rl_waddr;
    addr_t rl_raddr;
    addr_t el_waddr;
    addr_t el_raddr;
  } ctl_t;

endpackage

[rtl/heightmap_steepest_descent_erosion_top.sv]
// ----------------------------------------------------------------------------
// heightmap_steepest_descent_erosion_top
// Pipeline: a request is held in the input register, and the result that it
//   releases is then held in the result register.
// Throughput: one request per cycle while out_stall does not hold the output, set by the raw and eroded line memories.
// Reset: counters clear, map_size 1024, erosion_gain 6554; line memories are
//   not cleared and no clearing pass runs.
// ----------------------------------------------------------------------------
module heightmap_steepest_descent_erosion_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_op,
  input  logic [hsde_pkg::HEIGHT_W-1:0]    in_height,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [hsde_pkg::HEIGHT_W-1:0]    out_eroded_height,
  output logic                             out_last,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [hsde_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [hsde_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import hsde_pkg::*;

  logic    s1_valid_r, s1_valid_nxt;
  logic    s1_op_r;
  height_t s1_height_r;
  logic    out_valid_r, out_valid_nxt;
  height_t out_height_r;
  logic    out_last_r;

  logic              fire;
  ctl_t              ctl;
  logic [GAIN_W-1:0] gain;
  height_t           rl_q, el_q, eroded;

  assign cfg_ready = 1'b1;

  always_comb begin
    fire          = s1_valid_r && (!out_valid_r || !out_stall);
    in_stall      = s1_valid_r && !fire;
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;
    if (in_valid && !in_stall) begin
      s1_valid_nxt = 1'b1;
    end else if (fire) begin
      s1_valid_nxt = 1'b0;
    end
    if (fire) begin
      out_valid_nxt = ctl.produce;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_op_r     <= in_op;
      s1_height_r <= in_height;
    end
    if (fire && ctl.produce) begin
      out_height_r <= eroded;
      out_last_r   <= ctl.last;
    end
  end

  hsde_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fire      (fire),
    .op        (s1_op_r),
    .ctl       (ctl),
    .gain      (gain)
  );

  hsde_line_ram #(
    .DEPTH (MAX_MAP_SIZE),
    .WIDTH (HEIGHT_W)
  ) u_raw_line (
    .clk   (clk),
    .we    (ctl.pix),
    .waddr (ctl.rl_waddr),
    .wdata (s1_height_r),
    .raddr (ctl.rl_raddr),
    .rdata (rl_q)
  );

  hsde_line_ram #(
    .DEPTH (MAX_MAP_SIZE),
    .WIDTH (HEIGHT_W)
  ) u_eroded_line (
    .clk   (clk),
    .we    (ctl.produce),
    .waddr (ctl.el_waddr),
    .wdata (eroded),
    .raddr (ctl.el_raddr),
    .rdata (el_q)
  );

  hsde_erode u_erode (
    .clk    (clk),
    .ctl    (ctl),
    .height (s1_height_r),
    .rl_q   (rl_q),
    .el_q   (el_q),
    .gain   (gain),
    .eroded (eroded)
  );

  assign out_valid         = out_valid_r;
  assign out_eroded_height = out_height_r;
  assign out_last          = out_last_r;

endmodule

[rtl/hsde_line_ram.sv]
// ----------------------------------------------------------------------------
// hsde_line_ram
// Simple dual-port line memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module hsde_line_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/hsde_ctrl.sv]
// ----------------------------------------------------------------------------
// hsde_ctrl
// Configuration registers, raster counters, fill and tail tracking.
// ----------------------------------------------------------------------------
module hsde_ctrl (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [hsde_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [hsde_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 fire,
  input  logic                                 op,
  output hsde_pkg::ctl_t                       ctl,
  output logic [hsde_pkg::GAIN_W-1:0]          gain
);

  import hsde_pkg::*;

  logic [SIZE_W-1:0] size_r, size_nxt;
  logic [GAIN_W-1:0] gain_r, gain_nxt;
  addr_t             col_r, col_nxt;
  addr_t             row_r, row_nxt;
  addr_t             ex_r, ex_nxt;
  addr_t             ey_r, ey_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              tail_r, tail_nxt;

  logic [SIZE_W-1:0] size_m1;
  logic [SIZE_W-1:0] size_raw;
  logic [FILL_W-1:0] fill_top;
  logic              col_last, row_last, ex_last, ey_last;
  logic              pix_ok, drain_ok, fill_full, produce, frame_end;
  logic              size_we, gain_we;

  always_comb begin
    size_m1   = SIZE_W'(size_r - SIZE_W'(1));
    fill_top  = FILL_W'(FILL_W'(size_r) + FILL_W'(1));
    col_last  = (SIZE_W'(col_r) == size_m1);
    row_last  = (SIZE_W'(row_r) == size_m1);
    ex_last   = (SIZE_W'(ex_r) == size_m1);
    ey_last   = (SIZE_W'(ey_r) == size_m1);
    pix_ok    = fire && (op == OP_PIXEL) && !tail_r;
    drain_ok  = fire && (op == OP_DRAIN) && tail_r;
    fill_full = (fill_r == fill_top);
    produce   = (pix_ok && fill_full) || drain_ok;
    frame_end = drain_ok && ex_last && ey_last;
    size_we   = cfg_we && (cfg_index == REG_MAP_SIZE);
    gain_we   = cfg_we && (cfg_index == REG_EROSION_GAIN);
    size_raw  = cfg_data[SIZE_W-1:0];

    size_nxt = size_r;
    gain_nxt = gain_r;
    col_nxt  = col_r;
    row_nxt  = row_r;
    ex_nxt   = ex_r;
    ey_nxt   = ey_r;
    fill_nxt = fill_r;
    tail_nxt = tail_r;

    if (pix_ok || drain_ok) begin
      col_nxt = col_last ? '0 : ADDR_W'(col_r + ADDR_W'(1));
    end
    if (pix_ok && col_last) begin
      row_nxt = row_last ? '0 : ADDR_W'(row_r + ADDR_W'(1));
      if (row_last) begin
        tail_nxt = 1'b1;
      end
    end
    if (pix_ok && !fill_full) begin
      fill_nxt = FILL_W'(fill_r + FILL_W'(1));
    end
    if (produce) begin
      ex_nxt = ex_last ? '0 : ADDR_W'(ex_r + ADDR_W'(1));
      if (ex_last) begin
        ey_nxt = ey_last ? '0 : ADDR_W'(ey_r + ADDR_W'(1));
      end
    end

    if (gain_we) begin
      gain_nxt = cfg_data[GAIN_W-1:0];
    end
    if (size_we) begin
      if (size_raw < SIZE_W'(MIN_MAP_SIZE)) begin
        size_nxt = SIZE_W'(MIN_MAP_SIZE);
      end else if (size_raw > SIZE_W'(MAX_MAP_SIZE)) begin
        size_nxt = SIZE_W'(MAX_MAP_SIZE);
      end else begin
        size_nxt = size_raw;
      end
    end
    if (frame_end || size_we) begin
      col_nxt  = '0;
      row_nxt  = '0;
      ex_nxt   = '0;
      ey_nxt   = '0;
      fill_nxt = '0;
      tail_nxt = 1'b0;
    end

    ctl.pix      = pix_ok;
    ctl.adv      = pix_ok || drain_ok;
    ctl.produce  = produce;
    ctl.last     = frame_end;
    ctl.border   = (ex_r == '0) || (ey_r == '0) || ex_last || ey_last;
    ctl.rl_waddr = col_r;
    ctl.rl_raddr = col_nxt;
    ctl.el_waddr = ex_r;
    ctl.el_raddr = (SIZE_W'(ex_nxt) == size_m1) ? '0 : ADDR_W'(ex_nxt + ADDR_W'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SIZE_W'(SIZE_RESET);
      gain_r <= GAIN_W'(GAIN_RESET);
      col_r  <= '0;
      row_r  <= '0;
      ex_r   <= '0;
      ey_r   <= '0;
      fill_r <= '0;
      tail_r <= 1'b0;
    end else begin
      size_r <= size_nxt;
      gain_r <= gain_nxt;
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      ex_r   <= ex_nxt;
      ey_r   <= ey_nxt;
      fill_r <= fill_nxt;
      tail_r <= tail_nxt;
    end
  end

  assign gain = gain_r;

endmodule

[rtl/hsde_erode.sv]
// ----------------------------------------------------------------------------
// hsde_erode
// 3x3 window taps, neighbour minimum and gain-scaled erosion of one pixel.
// ----------------------------------------------------------------------------
module hsde_erode (
  input  logic                        clk,
  input  hsde_pkg::ctl_t              ctl,
  input  hsde_pkg::height_t           height,
  input  hsde_pkg::height_t           rl_q,
  input  hsde_pkg::height_t           el_q,
  input  logic [hsde_pkg::GAIN_W-1:0] gain,
  output hsde_pkg::height_t           eroded
);

  import hsde_pkg::*;

  // up row: u0, u1, el_q; mid: lo_r, mc_r, rl_q; down: d0, d1, height
  height_t u0_r, u1_r, lo_r, mc_r, d0_r, d1_r;
  height_t min_a, min_b, min_c, min_d, min_ab, min_cd, min_all;
  height_t diff;
  logic [PROD_W-1:0] prod;

  function automatic height_t min2(height_t a, height_t b);
    return (b < a) ? b : a;
  endfunction

  always_comb begin
    min_a   = min2(u0_r, u1_r);
    min_b   = min2(el_q, rl_q);
    min_c   = min2(d0_r, d1_r);
    min_d   = min2(height, lo_r);
    min_ab  = min2(min_a, min_b);
    min_cd  = min2(min_c, min_d);
    min_all = min2(min_ab, min_cd);
    diff    = HEIGHT_W'(mc_r - min_all);
    prod    = PROD_W'(diff) * PROD_W'(gain);
    if (!ctl.border && (min_all < mc_r)) begin
      eroded = HEIGHT_W'(mc_r - prod[PROD_W-1:GAIN_W]);
    end else begin
      eroded = mc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      mc_r <= rl_q;
    end
    if (ctl.pix) begin
      d0_r <= d1_r;
      d1_r <= height;
    end
    if (ctl.produce) begin
      u0_r <= u1_r;
      u1_r <= el_q;
      lo_r <= eroded;
    end
  end

endmodule
